>>> hw/rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/slcp_pkg.sv
// ----------------------------------------------------------------------------
// slcp_pkg
// Types, codes and the opcode size table of the sound log command parser.
// ----------------------------------------------------------------------------
`default_nettype none

package slcp_pkg;

  localparam logic [7:0] OP_MIN_VALID = 8'h30;
  localparam logic [7:0] OP_END       = 8'h66;
  localparam logic [7:0] OP_DATA_BLK  = 8'h67;
  localparam logic [7:0] OP_PCM_RAM   = 8'h68;
  localparam logic [7:0] BLK_MARKER   = 8'h66;

  localparam logic [3:0] PCM_OPERANDS = 4'd10;
  localparam logic [2:0] BLK_HDR_LAST = 3'd5;

  typedef enum logic [2:0] {
    PH_OPCODE   = 3'd0,
    PH_OPERANDS = 3'd1,
    PH_BLKHDR   = 3'd2,
    PH_PAYLOAD  = 3'd3,
    PH_PCMHDR   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_DONE  = 2'd1,
    ST_BAD   = 2'd2,
    ST_EARLY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ROLE_OPCODE  = 3'd0,
    ROLE_OPERAND = 3'd1,
    ROLE_HEADER  = 3'd2,
    ROLE_PAYLOAD = 3'd3,
    ROLE_NONE    = 3'd4
  } role_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } cmd_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic [2:0] byte_role;
    logic [7:0] current_command;
    logic [3:0] operand_index;
    logic       command_done;
    logic [7:0] block_kind;
    logic [1:0] parse_status;
  } tag_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  held_command;
    logic [3:0]  operands_left;
    logic [3:0]  operand_position;
    logic [2:0]  header_position;
    logic [7:0]  held_block_kind;
    logic [31:0] payload_left;
    status_t     status;
    logic        marker_bad;
  } parse_state_t;

  typedef struct packed {
    logic       bad;
    logic [2:0] count;
  } op_info_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_OPCODE, held_command: 8'h00, operands_left: 4'd0,
    operand_position: 4'd0, header_position: 3'd0, held_block_kind: 8'h00,
    payload_left: 32'd0, status: ST_RUN, marker_bad: 1'b0
  };

  // operand count of an opcode; 0x67 and 0x68 report zero and are handled apart
  function automatic op_info_t op_size(input logic [7:0] op);
    op_info_t info;
    info = '{bad: 1'b0, count: 3'd0};
    case (op) inside
      [8'h00:8'h2F]:        info.bad = 1'b1;
      [8'h30:8'h3F]:        info.count = 3'd1;
      [8'h40:8'h4E]:        info.count = 3'd2;
      [8'h4F:8'h50]:        info.count = 3'd1;
      [8'h51:8'h5F]:        info.count = 3'd2;
      8'h60, 8'h65:         info.bad = 1'b1;
      8'h61:                info.count = 3'd2;
      8'h64:                info.count = 3'd3;
      8'h62, 8'h63,
      [8'h66:8'h68]:        info.count = 3'd0;
      [8'h69:8'h6F]:        info.bad = 1'b1;
      [8'h70:8'h95]:        info.count = 3'd0;
      [8'h96:8'h9F]:        info.bad = 1'b1;
      [8'hA0:8'hBF]:        info.count = 3'd2;
      [8'hC0:8'hDF]:        info.count = 3'd3;
      default:              info.count = 3'd4;
    endcase
    return info;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sound_log_command_parser.sv
// ----------------------------------------------------------------------------
// sound_log_command_parser
// Tags each byte of a music log command stream with its role in the parse.
// ----------------------------------------------------------------------------
// Takes one stream byte (or an end mark) per request on cmd_* and returns
// exactly one tag per request on tag_*. The parse step is a single pass of
// logic between the parser state registers and the tag register, so a new
// byte is accepted every cycle as long as the tag register is empty or
// being drained in that same cycle. Errors and the finish status are sticky
// until reset.
`default_nettype none

`include "assert_macros.svh"

module sound_log_command_parser import slcp_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd_data,
  output logic tag_valid,
  input  wire  tag_ready,
  output tag_t tag_data
);

  parse_state_t state;
  parse_state_t state_next;
  tag_t         tag_next;
  logic         accept;

  assign cmd_ready = !tag_valid || tag_ready;
  assign accept    = cmd_valid && cmd_ready;

  slcp_step u_step (
    .state      (state),
    .cmd        (cmd_data),
    .state_next (state_next),
    .tag        (tag_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_RESET;
      tag_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (accept) begin
        tag_valid <= 1'b1;
      end else if (tag_ready) begin
        tag_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_data <= tag_next;
    end
  end

  // a stopped parse never moves again
  `ASSERT_NEXT(a_sticky_status, clk, rst, state.status != ST_RUN, $stable(state))
  // payload phase always has bytes still to come
  `ASSERT_IMPLIES(a_payload_nonzero, clk, rst, state.phase == PH_PAYLOAD, state.payload_left != 32'd0)
  // untagged bytes carry no command
  `ASSERT_IMPLIES(a_none_no_cmd, clk, rst, tag_valid && tag_data.byte_role == ROLE_NONE, tag_data.current_command == 8'h00 && !tag_data.command_done)
  // only opcode or operand bytes complete a command
  `ASSERT_IMPLIES(a_done_role, clk, rst, tag_valid && tag_data.command_done, tag_data.byte_role == ROLE_OPCODE || tag_data.byte_role == ROLE_OPERAND)

endmodule

`default_nettype wire

>>> hw/rtl/slcp_step.sv
// ----------------------------------------------------------------------------
// slcp_step
// Combinational parse step: tags one stream byte and works out the next
// parser state.
// ----------------------------------------------------------------------------
`default_nettype none

module slcp_step import slcp_pkg::*; (
  input  parse_state_t state,
  input  cmd_t         cmd,
  output parse_state_t state_next,
  output tag_t         tag
);

  logic [7:0]  b;
  op_info_t    info;
  logic [2:0]  hdr_pos_inc;
  logic [1:0]  lane;
  logic [31:0] payload_or;
  logic [31:0] payload_dec;

  assign b           = cmd.end_of_input ? 8'h00 : cmd.data_byte;
  assign info        = op_size(b);
  assign hdr_pos_inc = state.header_position + 3'd1;
  assign lane        = state.header_position[1:0] - 2'd2;
  assign payload_dec = state.payload_left - 32'd1;

  always_comb begin
    payload_or = state.payload_left;
    case (lane)
      2'd0:    payload_or[7:0]   = state.payload_left[7:0]   | b;
      2'd1:    payload_or[15:8]  = state.payload_left[15:8]  | b;
      2'd2:    payload_or[23:16] = state.payload_left[23:16] | b;
      default: payload_or[31:24] = state.payload_left[31:24] | b;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    if (state.status != ST_RUN) begin
      state_next = state;
    end else if (cmd.end_of_input) begin
      state_next.status = ST_EARLY;
    end else begin
      case (state.phase)
        PH_OPCODE: begin
          state_next.held_command = b;
          if (info.bad) begin
            state_next.status = ST_BAD;
          end else if (b == OP_DATA_BLK) begin
            state_next.phase           = PH_BLKHDR;
            state_next.header_position = 3'd0;
            state_next.payload_left    = 32'd0;
            state_next.marker_bad      = 1'b0;
          end else if (b == OP_PCM_RAM) begin
            state_next.phase      = PH_PCMHDR;
            state_next.marker_bad = 1'b0;
          end else if (info.count == 3'd0) begin
            if (b == OP_END) begin
              state_next.status = ST_DONE;
            end
          end else begin
            state_next.phase            = PH_OPERANDS;
            state_next.operands_left    = {1'b0, info.count};
            state_next.operand_position = 4'd0;
            state_next.marker_bad       = 1'b0;
          end
        end
        PH_OPERANDS: begin
          state_next.operand_position = state.operand_position + 4'd1;
          state_next.operands_left    = state.operands_left - 4'd1;
          if (state.operands_left == 4'd1) begin
            state_next.phase = PH_OPCODE;
            if (state.marker_bad) begin
              state_next.status = ST_BAD;
            end
          end
        end
        PH_BLKHDR: begin
          if (state.header_position == 3'd0) begin
            state_next.marker_bad = (b != BLK_MARKER);
          end else if (state.header_position == 3'd1) begin
            state_next.held_block_kind = b;
          end else begin
            state_next.payload_left = payload_or;
          end
          state_next.header_position = hdr_pos_inc;
          if (state.header_position >= BLK_HDR_LAST) begin
            state_next.header_position = 3'd0;
            if (state_next.marker_bad) begin
              state_next.status = ST_BAD;
            end else if (state_next.payload_left == 32'd0) begin
              state_next.phase = PH_OPCODE;
            end else begin
              state_next.phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          state_next.payload_left = payload_dec;
          if (payload_dec == 32'd0) begin
            state_next.phase = PH_OPCODE;
          end
        end
        PH_PCMHDR: begin
          state_next.marker_bad       = (b != BLK_MARKER);
          state_next.phase            = PH_OPERANDS;
          state_next.operands_left    = PCM_OPERANDS;
          state_next.operand_position = 4'd0;
        end
        default: begin
          state_next.phase = PH_OPCODE;
        end
      endcase
    end
  end

  // result tag
  always_comb begin
    tag                 = '0;
    tag.byte_value      = b;
    tag.byte_role       = ROLE_NONE;
    tag.parse_status    = state_next.status;
    if (state.status == ST_RUN && !cmd.end_of_input) begin
      case (state.phase)
        PH_OPCODE: begin
          tag.byte_role       = ROLE_OPCODE;
          tag.current_command = b;
          tag.command_done    = !info.bad && info.count == 3'd0 &&
                                b != OP_DATA_BLK && b != OP_PCM_RAM;
        end
        PH_OPERANDS: begin
          tag.byte_role       = ROLE_OPERAND;
          tag.current_command = state.held_command;
          tag.operand_index   = state.operand_position;
          tag.command_done    = state.operands_left == 4'd1 && !state.marker_bad;
        end
        PH_BLKHDR: begin
          tag.byte_role       = ROLE_HEADER;
          tag.current_command = state.held_command;
          if (state.header_position != 3'd0) begin
            tag.block_kind = state_next.held_block_kind;
          end
        end
        PH_PAYLOAD: begin
          tag.byte_role       = ROLE_PAYLOAD;
          tag.current_command = state.held_command;
          tag.block_kind      = state.held_block_kind;
        end
        PH_PCMHDR: begin
          tag.byte_role       = ROLE_HEADER;
          tag.current_command = state.held_command;
        end
        default: begin
          tag.byte_role = ROLE_NONE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sound log command parser.
// ----------------------------------------------------------------------------
// Drives one command stream through the parser over the request channel and
// predicts every tag in a scoreboard that keeps its own copy of the parse
// state. There is only one reset, so the stream stays well formed for most of
// the run. It opens with fixed commands at the operand extremes and then runs
// random commands, data blocks and pcm writes. One stop event, picked at
// random, ends the parse, and a tail of bytes and end marks follows it. Both
// channels idle and stall in rotating phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slcp_pkg::*;

  localparam int unsigned ITEM_TARGET = 750;
  localparam int unsigned TAIL_ITEMS  = 20;

  // opcodes used by the opening commands
  localparam logic [7:0] OP_TWO_ARG_LAST  = 8'h5F;
  localparam logic [7:0] OP_FOUR_ARG_LAST = 8'hFF;
  localparam logic [7:0] OP_SHORT_WAIT    = 8'h70;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
  typedef enum {
    STOP_FINISH, STOP_BAD_OPCODE, STOP_END_IDLE, STOP_END_MID,
    STOP_BAD_BLOCK_MARKER, STOP_BAD_PCM_MARKER
  } stop_t;

  class parse_tracker;
    phase_t      phase;
    status_t     status;
    logic [7:0]  held_op;
    logic [3:0]  ops_left;
    logic [3:0]  op_pos;
    logic [2:0]  hdr_pos;
    logic [7:0]  blk_kind;
    logic [31:0] pay_left;
    bit          marker_bad;
    tag_t        pending_tags[$];
    int unsigned errors;

    function new();
      phase      = PH_OPCODE;
      status     = ST_RUN;
      held_op    = '0;
      ops_left   = '0;
      op_pos     = '0;
      hdr_pos    = '0;
      blk_kind   = '0;
      pay_left   = '0;
      marker_bad = 1'b0;
      errors     = 0;
    endfunction

    // operands that follow an opcode, -1 for an opcode with no table entry
    static function int operand_count(logic [7:0] op);
      if (op < OP_MIN_VALID) return -1;
      if (op <= 8'h3F) return 1;
      if (op <= 8'h4E) return 2;
      if (op <= 8'h50) return 1;
      if (op <= 8'h5F) return 2;
      if (op == 8'h60 || op == 8'h65) return -1;
      if (op == 8'h61) return 2;
      if (op == 8'h64) return 3;
      if (op <= OP_PCM_RAM) return 0;
      if (op <= 8'h6F) return -1;
      if (op <= 8'h95) return 0;
      if (op <= 8'h9F) return -1;
      if (op <= 8'hBF) return 2;
      if (op <= 8'hDF) return 3;
      return 4;
    endfunction

    function void take_request(cmd_t c);
      tag_t       t;
      int         n;
      int         sh;
      logic [7:0] b;
      t = '0;
      t.byte_role = ROLE_NONE;
      b = c.end_of_input ? 8'h00 : c.data_byte;
      t.byte_value = b;
      if (status != ST_RUN) begin
        // parse stopped, nothing moves
      end else if (c.end_of_input) begin
        status = ST_EARLY;
      end else begin
        case (phase)
          PH_OPCODE: begin
            n = operand_count(b);
            t.byte_role = ROLE_OPCODE;
            t.current_command = b;
            held_op = b;
            if (n < 0) begin
              status = ST_BAD;
            end else if (b == OP_DATA_BLK) begin
              phase = PH_BLKHDR;
              hdr_pos = '0;
              pay_left = '0;
              marker_bad = 1'b0;
            end else if (b == OP_PCM_RAM) begin
              phase = PH_PCMHDR;
              marker_bad = 1'b0;
            end else if (n == 0) begin
              t.command_done = 1'b1;
              if (b == OP_END) status = ST_DONE;
            end else begin
              phase = PH_OPERANDS;
              ops_left = 4'(n);
              op_pos = '0;
              marker_bad = 1'b0;
            end
          end
          PH_OPERANDS: begin
            t.byte_role = ROLE_OPERAND;
            t.current_command = held_op;
            t.operand_index = op_pos;
            op_pos = op_pos + 4'd1;
            ops_left = ops_left - 4'd1;
            if (ops_left == 0) begin
              phase = PH_OPCODE;
              if (marker_bad) status = ST_BAD;
              else t.command_done = 1'b1;
            end
          end
          PH_BLKHDR: begin
            t.byte_role = ROLE_HEADER;
            t.current_command = held_op;
            if (hdr_pos == 0) begin
              marker_bad = (b != BLK_MARKER);
            end else if (hdr_pos == 1) begin
              blk_kind = b;
            end else begin
              sh = 8 * (int'(hdr_pos) - 2);
              pay_left = pay_left | (32'(b) << sh);
            end
            if (hdr_pos != 0) t.block_kind = blk_kind;
            if (hdr_pos == BLK_HDR_LAST) begin
              hdr_pos = '0;
              if (marker_bad) status = ST_BAD;
              else if (pay_left == 0) phase = PH_OPCODE;
              else phase = PH_PAYLOAD;
            end else begin
              hdr_pos = hdr_pos + 3'd1;
            end
          end
          PH_PAYLOAD: begin
            t.byte_role = ROLE_PAYLOAD;
            t.current_command = held_op;
            t.block_kind = blk_kind;
            pay_left = pay_left - 32'd1;
            if (pay_left == 0) phase = PH_OPCODE;
          end
          PH_PCMHDR: begin
            t.byte_role = ROLE_HEADER;
            t.current_command = held_op;
            marker_bad = (b != BLK_MARKER);
            phase = PH_OPERANDS;
            ops_left = PCM_OPERANDS;
            op_pos = '0;
          end
          default: phase = PH_OPCODE;
        endcase
      end
      t.parse_status = status;
      pending_tags.push_back(t);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    function void check_tag(tag_t got);
      tag_t want;
      if (pending_tags.size() == 0) begin
        errors++;
        $display("%0t: tag with no request pending, expected none got %h", $time, got);
        return;
      end
      want = pending_tags.pop_front();
      compare_field("byte_value", 32'(want.byte_value), 32'(got.byte_value));
      compare_field("byte_role", 32'(want.byte_role), 32'(got.byte_role));
      compare_field("current_command", 32'(want.current_command),
                    32'(got.current_command));
      compare_field("operand_index", 32'(want.operand_index), 32'(got.operand_index));
      compare_field("command_done", 32'(want.command_done), 32'(got.command_done));
      compare_field("block_kind", 32'(want.block_kind), 32'(got.block_kind));
      compare_field("parse_status", 32'(want.parse_status), 32'(got.parse_status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd_data = '0;
  logic tag_valid;
  logic tag_ready = 1'b0;
  tag_t tag_data;

  parse_tracker tracker = new();
  int unsigned  requests_sent = 0;
  int unsigned  sender_idle_pct = 0;
  int unsigned  receiver_stall_pct = 0;

  sound_log_command_parser dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .tag_valid (tag_valid),
    .tag_ready (tag_ready),
    .tag_data  (tag_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("sound_log_command_parser verification failed");
    $finish;
  end

  // tag side: check what was taken at this edge, then pick the next ready
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && tag_valid && tag_ready) tracker.check_tag(tag_data);
      tag_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic send_item(input cmd_t c);
    case ((requests_sent / 50) % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
      default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
    endcase
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data <= c;
    do @(posedge clk); while (!(cmd_valid && cmd_ready));
    tracker.take_request(c);
    requests_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    cmd_t c;
    c.data_byte = b;
    c.end_of_input = 1'b0;
    send_item(c);
  endtask

  task automatic send_end();
    cmd_t c;
    c.data_byte = 8'($urandom);
    c.end_of_input = 1'b1;
    send_item(c);
  endtask

  function automatic logic [7:0] operand_byte(input fill_t fill);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return 8'($urandom);
    endcase
  endfunction

  // whole command; a broken marker leaves the block payload out
  task automatic send_command(input logic [7:0] op, input int unsigned blk_size,
                              input fill_t fill, input bit bad_marker = 1'b0);
    int          n;
    logic [7:0]  mark;
    logic [31:0] size;
    n = parse_tracker::operand_count(op);
    size = blk_size;
    send_byte(op);
    if (op == OP_DATA_BLK || op == OP_PCM_RAM) begin
      mark = BLK_MARKER;
      while (bad_marker && mark == BLK_MARKER) mark = 8'($urandom);
      send_byte(mark);
      if (op == OP_DATA_BLK) begin
        send_byte(operand_byte(fill));
        for (int i = 0; i < 4; i++) send_byte(size[8*i +: 8]);
        if (!bad_marker) repeat (blk_size) send_byte(operand_byte(fill));
      end else begin
        repeat (PCM_OPERANDS) send_byte(operand_byte(fill));
      end
    end else begin
      repeat (n) send_byte(operand_byte(fill));
    end
  endtask

  function automatic logic [7:0] pick_opcode();
    logic [7:0] op;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return OP_DATA_BLK;
    if (roll < 15) return OP_PCM_RAM;
    do op = 8'($urandom);
    while (parse_tracker::operand_count(op) < 0 || op == OP_END);
    return op;
  endfunction

  // mostly short blocks, now and then a longer one
  function automatic int unsigned pick_block_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(4);
    if (roll < 95) return $urandom_range(16, 5);
    return $urandom_range(64, 17);
  endfunction

  initial begin
    stop_t      stop_kind;
    logic [7:0] op;
    cmd_t       c;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_command(OP_MIN_VALID, 0, FILL_ONES);
    send_command(OP_TWO_ARG_LAST, 0, FILL_ZERO);
    send_command(OP_FOUR_ARG_LAST, 0, FILL_ONES);
    send_command(OP_FOUR_ARG_LAST, 0, FILL_ZERO);
    send_command(OP_SHORT_WAIT, 0, FILL_RANDOM);
    // empty block, then a one-byte block
    send_command(OP_DATA_BLK, 0, FILL_ONES);
    send_command(OP_DATA_BLK, 1, FILL_ZERO);

    while (requests_sent < ITEM_TARGET) send_command(pick_opcode(), pick_block_size(),
                                                     FILL_RANDOM);

    stop_kind = stop_t'($urandom_range(STOP_BAD_PCM_MARKER));
    case (stop_kind)
      STOP_FINISH: send_byte(OP_END);
      STOP_BAD_OPCODE: begin
        do op = 8'($urandom); while (parse_tracker::operand_count(op) >= 0);
        send_byte(op);
      end
      STOP_END_IDLE: send_end();
      STOP_END_MID: begin
        // cut the header short, marker may or may not be right
        op = $urandom_range(1) ? OP_PCM_RAM : OP_DATA_BLK;
        send_byte(op);
        repeat ($urandom_range(op == OP_PCM_RAM ? 10 : 5)) send_byte(8'($urandom));
        send_end();
      end
      STOP_BAD_BLOCK_MARKER: send_command(OP_DATA_BLK, pick_block_size(), FILL_RANDOM, 1'b1);
      default: send_command(OP_PCM_RAM, 0, FILL_RANDOM, 1'b1);
    endcase

    repeat (TAIL_ITEMS) begin
      c.data_byte = 8'($urandom);
      c.end_of_input = ($urandom_range(3) == 0);
      send_item(c);
    end
    cmd_valid <= 1'b0;

    while (tracker.pending_tags.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_tags.size() == 0) begin
      $display("sound_log_command_parser verification clean");
    end else begin
      $display("sound_log_command_parser verification failed");
    end
    $finish;
  end

endmodule
